### hdl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg: shared constants and types for the balance robot controller
// Widths, loop constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

  typedef logic signed [63:0] word_t;

  localparam int AVERAGE_SAMPLES = 100;
  localparam int MUL_W     = 16;
  localparam int MUL_STEPS = MUL_W;
  localparam int DIV_STEPS = 50;
  localparam int DEN_W     = 24;

  localparam word_t DRIVE_LIMIT = 64'sd6900;
  localparam word_t INTEG_LIMIT = 64'sd655360000;
  localparam word_t INT32_HI    = 64'sd2147483647;
  localparam word_t INT32_LO    = -64'sd2147483648;
  localparam word_t ROUND_Q16   = 64'sd32768;

  localparam logic signed [15:0] TILT_LIMIT  = 16'sd4000;
  localparam logic        [11:0] LOW_VOLTAGE = 12'd1110;
  localparam logic [MUL_W-1:0]   KEEP_Q16    = 16'd56361;
  localparam logic [MUL_W-1:0]   TAKE_Q16    = 16'd9175;
  localparam logic [DEN_W-1:0]   BAL_SCALE   = 24'd10000;
  localparam logic [DEN_W-1:0]   VEL_SCALE   = 24'd6553600;

  typedef enum logic [2:0] {
    REG_TILT_KP    = 3'd0,
    REG_TILT_KD    = 3'd1,
    REG_SPEED_KP   = 3'd2,
    REG_SPEED_KI   = 3'd3,
    REG_STEER_KP   = 3'd4,
    REG_STEER_KD   = 3'd5,
    REG_LEVEL      = 3'd6,
    REG_MOVE_SPEED = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOLT,
    ST_BAL_P,
    ST_BAL_D,
    ST_BAL_Q,
    ST_FLT_K,
    ST_FLT_E,
    ST_MOVE,
    ST_INTEG,
    ST_VEL_P,
    ST_VEL_I,
    ST_VEL_Q,
    ST_TRN_Y,
    ST_TRN_D,
    ST_TRN_Q,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### hdl/balance_robot_cascaded_pid.sv
// ----------------------------------------------------------------------------
// balance_robot_cascaded_pid: two-wheel balance, speed and turn controller
// Sequencer over a shared bit-serial multiplier and divider.
//
//   channel   direction  content
//   s_axis    in         one tick: sensors, battery sample, remote commands
//   m_axis    out        wheel drives and motor shutdown flag, control ticks only
//   cfg       in         gain and offset register writes
//
// Sampling ticks run a divide only when the battery average is latched.
// Control ticks run eight 16-step multiplies and four 50-step divides on the
// serial units, one bit per cycle each.
// Reset is synchronous; it clears all control state, no clearing pass.
// A new tick is taken once the sequencer is idle; a stalled result holds in the
// output register and the last control step waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_robot_cascaded_pid (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tilt_angle, tilt_rate, yaw_rate, left_count, right_count, battery_sample,
  // go_forward, go_backward, go_left, go_right, stop_request, speed_divisor
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // left_drive, right_drive, motors_off
  output logic [31:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  typedef bcp_pkg::word_t word_t;

  // configuration
  logic [15:0]        tilt_kp, tilt_kd, speed_kp, speed_ki, steer_kp, steer_kd;
  logic signed [12:0] level_angle;
  logic [9:0]         move_speed;

  // latched tick
  logic signed [15:0] tilt_angle, tilt_rate, yaw_rate, left_count, right_count;
  logic               go_forward, go_backward, go_left, go_right, stop_request;
  logic [7:0]         speed_divisor;

  // state
  bcp_pkg::state_t    state, state_next;
  logic               launched;
  logic               control_phase;
  logic [18:0]        volt_sum;
  logic [6:0]         volt_count;
  logic [11:0]        volt_average;
  logic signed [31:0] filtered_speed_error, speed_integral;

  // working registers
  word_t              acc;
  logic signed [31:0] bal, vel, trn, move, integ;

  logic                       mul_start, mul_done, div_start, div_done;
  word_t                      mul_a, prod, div_num, quot;
  logic [bcp_pkg::MUL_W-1:0]  mul_b;
  logic [bcp_pkg::DEN_W-1:0]  div_den;

  logic        in_fire, out_free, off;
  logic [6:0]  count_inc;
  logic [7:0]  divx;
  word_t       diff, rate100, err_w, k54, steer_term, flt_sum, flt_q, integ_sum;
  word_t       l_sum, r_sum, l_clamp, r_clamp;
  logic [bcp_pkg::DEN_W-1:0] den_trn, den_div;
  logic [15:0] kd_sel;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = state == bcp_pkg::ST_IDLE;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign count_inc     = volt_count + 7'd1;

  assign divx    = (speed_divisor == 8'd0) ? 8'd1 : speed_divisor;
  assign den_div = {16'd0, divx};
  assign den_trn = (den_div << 6) + (den_div << 5) + (den_div << 2);
  assign kd_sel  = (go_forward || go_backward) ? steer_kd : 16'd0;

  assign diff    = word_t'(tilt_angle) - word_t'(level_angle);
  assign rate100 = (word_t'(tilt_rate) <<< 6) + (word_t'(tilt_rate) <<< 5)
                 + (word_t'(tilt_rate) <<< 2);
  assign err_w   = -(word_t'(left_count) + word_t'(right_count));
  assign k54     = (word_t'({48'd0, steer_kp}) <<< 5) + (word_t'({48'd0, steer_kp}) <<< 4)
                 + (word_t'({48'd0, steer_kp}) <<< 2) + (word_t'({48'd0, steer_kp}) <<< 1);
  assign steer_term = go_left ? -k54 : (go_right ? k54 : '0);

  assign flt_sum = acc + (prod <<< 16) + bcp_pkg::ROUND_Q16;
  assign flt_q   = flt_sum >>> 16;
  assign integ_sum = word_t'(speed_integral) + word_t'(filtered_speed_error)
                   + word_t'(move);

  assign off = (tilt_angle > bcp_pkg::TILT_LIMIT) || (tilt_angle < -bcp_pkg::TILT_LIMIT)
            || stop_request || (volt_average < bcp_pkg::LOW_VOLTAGE);

  assign l_sum = word_t'(bal) + word_t'(vel) + word_t'(trn);
  assign r_sum = word_t'(bal) + word_t'(vel) - word_t'(trn);
  assign l_clamp = (l_sum > bcp_pkg::DRIVE_LIMIT) ? bcp_pkg::DRIVE_LIMIT :
                   (l_sum < -bcp_pkg::DRIVE_LIMIT) ? -bcp_pkg::DRIVE_LIMIT : l_sum;
  assign r_clamp = (r_sum > bcp_pkg::DRIVE_LIMIT) ? bcp_pkg::DRIVE_LIMIT :
                   (r_sum < -bcp_pkg::DRIVE_LIMIT) ? -bcp_pkg::DRIVE_LIMIT : r_sum;

  bcp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  bcp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = bcp_pkg::BAL_SCALE;
    unique case (state)
      bcp_pkg::ST_BAL_P: begin mul_a = diff;    mul_b = tilt_kp; end
      bcp_pkg::ST_BAL_D: begin mul_a = rate100; mul_b = tilt_kd; end
      bcp_pkg::ST_FLT_K: begin
        mul_a = word_t'(filtered_speed_error);
        mul_b = bcp_pkg::KEEP_Q16;
      end
      bcp_pkg::ST_FLT_E: begin mul_a = err_w; mul_b = bcp_pkg::TAKE_Q16; end
      bcp_pkg::ST_VEL_P: begin mul_a = word_t'(filtered_speed_error); mul_b = speed_kp; end
      bcp_pkg::ST_VEL_I: begin mul_a = word_t'(integ); mul_b = speed_ki; end
      bcp_pkg::ST_TRN_Y: begin mul_a = word_t'(yaw_rate); mul_b = kd_sel; end
      bcp_pkg::ST_TRN_D: begin mul_a = acc; mul_b = {8'd0, divx}; end
      bcp_pkg::ST_VOLT: begin
        div_num = word_t'({45'd0, volt_sum});
        div_den = bcp_pkg::DEN_W'(bcp_pkg::AVERAGE_SAMPLES);
      end
      bcp_pkg::ST_BAL_Q: begin div_num = acc; div_den = bcp_pkg::BAL_SCALE; end
      bcp_pkg::ST_MOVE: begin
        div_num = word_t'({38'd0, move_speed, 16'd0});
        div_den = den_div;
      end
      bcp_pkg::ST_VEL_Q: begin div_num = -acc; div_den = bcp_pkg::VEL_SCALE; end
      bcp_pkg::ST_TRN_Q: begin div_num = acc; div_den = den_trn; end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      bcp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (control_phase) begin
            state_next = bcp_pkg::ST_BAL_P;
          end else if (count_inc == 7'(bcp_pkg::AVERAGE_SAMPLES)) begin
            state_next = bcp_pkg::ST_VOLT;
          end
        end
      end
      bcp_pkg::ST_VOLT: begin
        div_start = !launched;
        if (div_done) state_next = bcp_pkg::ST_IDLE;
      end
      bcp_pkg::ST_BAL_P: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_BAL_D;
      end
      bcp_pkg::ST_BAL_D: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_BAL_Q;
      end
      bcp_pkg::ST_BAL_Q: begin
        div_start = !launched;
        if (div_done) state_next = bcp_pkg::ST_FLT_K;
      end
      bcp_pkg::ST_FLT_K: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_FLT_E;
      end
      bcp_pkg::ST_FLT_E: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_MOVE;
      end
      bcp_pkg::ST_MOVE: begin
        div_start = !launched;
        if (div_done) state_next = bcp_pkg::ST_INTEG;
      end
      bcp_pkg::ST_INTEG: state_next = bcp_pkg::ST_VEL_P;
      bcp_pkg::ST_VEL_P: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_VEL_I;
      end
      bcp_pkg::ST_VEL_I: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_VEL_Q;
      end
      bcp_pkg::ST_VEL_Q: begin
        div_start = !launched;
        if (div_done) state_next = bcp_pkg::ST_TRN_Y;
      end
      bcp_pkg::ST_TRN_Y: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_TRN_D;
      end
      bcp_pkg::ST_TRN_D: begin
        mul_start = !launched;
        if (mul_done) state_next = bcp_pkg::ST_TRN_Q;
      end
      bcp_pkg::ST_TRN_Q: begin
        div_start = !launched;
        if (div_done) state_next = bcp_pkg::ST_OUT;
      end
      bcp_pkg::ST_OUT: begin
        if (out_free) state_next = bcp_pkg::ST_IDLE;
      end
      default: state_next = bcp_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      launched             <= 1'b0;
      control_phase        <= 1'b0;
      volt_sum             <= '0;
      volt_count           <= '0;
      volt_average         <= '0;
      filtered_speed_error <= '0;
      speed_integral       <= '0;
      tilt_kp              <= '0;
      tilt_kd              <= '0;
      speed_kp             <= '0;
      speed_ki             <= '0;
      steer_kp             <= '0;
      steer_kd             <= '0;
      level_angle          <= '0;
      move_speed           <= 10'd35;
      m_axis_tvalid        <= 1'b0;
    end else begin
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end else if (mul_done || div_done) begin
        launched <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (bcp_pkg::reg_index_t'(cfg_index))
          bcp_pkg::REG_TILT_KP:    tilt_kp     <= cfg_data;
          bcp_pkg::REG_TILT_KD:    tilt_kd     <= cfg_data;
          bcp_pkg::REG_SPEED_KP:   speed_kp    <= cfg_data;
          bcp_pkg::REG_SPEED_KI:   speed_ki    <= cfg_data;
          bcp_pkg::REG_STEER_KP:   steer_kp    <= cfg_data;
          bcp_pkg::REG_STEER_KD:   steer_kd    <= cfg_data;
          bcp_pkg::REG_LEVEL:      level_angle <= cfg_data[12:0];
          bcp_pkg::REG_MOVE_SPEED: move_speed  <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        control_phase <= !control_phase;
        if (!control_phase) begin
          volt_sum   <= volt_sum + {7'd0, s_axis_tdata[91:80]};
          volt_count <= count_inc;
        end
      end

      // latch the average, restart the sum
      if (state == bcp_pkg::ST_VOLT && div_done) begin
        volt_average <= quot[11:0];
        volt_sum     <= '0;
        volt_count   <= '0;
      end

      if (state == bcp_pkg::ST_FLT_E && mul_done) begin
        if (flt_q > bcp_pkg::INT32_HI) begin
          filtered_speed_error <= 32'sh7FFFFFFF;
        end else if (flt_q < bcp_pkg::INT32_LO) begin
          filtered_speed_error <= 32'sh80000000;
        end else begin
          filtered_speed_error <= flt_q[31:0];
        end
      end

      // shutdown drops the integral, the clamped value still feeds this tick
      if (state == bcp_pkg::ST_INTEG) begin
        if (off) begin
          speed_integral <= '0;
        end else if (integ_sum > bcp_pkg::INTEG_LIMIT) begin
          speed_integral <= bcp_pkg::INTEG_LIMIT[31:0];
        end else if (integ_sum < -bcp_pkg::INTEG_LIMIT) begin
          speed_integral <= 32'(-bcp_pkg::INTEG_LIMIT);
        end else begin
          speed_integral <= integ_sum[31:0];
        end
      end

      if (state == bcp_pkg::ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tilt_angle    <= s_axis_tdata[15:0];
      tilt_rate     <= s_axis_tdata[31:16];
      yaw_rate      <= s_axis_tdata[47:32];
      left_count    <= s_axis_tdata[63:48];
      right_count   <= s_axis_tdata[79:64];
      go_forward    <= s_axis_tdata[92];
      go_backward   <= s_axis_tdata[93];
      go_left       <= s_axis_tdata[94];
      go_right      <= s_axis_tdata[95];
      stop_request  <= s_axis_tdata[96];
      speed_divisor <= s_axis_tdata[104:97];
    end

    if (mul_done) begin
      unique case (state)
        bcp_pkg::ST_BAL_P, bcp_pkg::ST_FLT_K, bcp_pkg::ST_VEL_P,
        bcp_pkg::ST_TRN_Y: acc <= prod;
        bcp_pkg::ST_BAL_D, bcp_pkg::ST_VEL_I: acc <= acc + prod;
        bcp_pkg::ST_TRN_D: acc <= prod + steer_term;
        default: ;
      endcase
    end

    if (div_done) begin
      unique case (state)
        bcp_pkg::ST_BAL_Q: bal <= quot[31:0];
        bcp_pkg::ST_MOVE:  move <= go_forward ? quot[31:0] :
                                   (go_backward ? -quot[31:0] : 32'sd0);
        bcp_pkg::ST_VEL_Q: vel <= quot[31:0];
        bcp_pkg::ST_TRN_Q: trn <= quot[31:0];
        default: ;
      endcase
    end

    if (state == bcp_pkg::ST_INTEG) begin
      if (integ_sum > bcp_pkg::INTEG_LIMIT) begin
        integ <= bcp_pkg::INTEG_LIMIT[31:0];
      end else if (integ_sum < -bcp_pkg::INTEG_LIMIT) begin
        integ <= 32'(-bcp_pkg::INTEG_LIMIT);
      end else begin
        integ <= integ_sum[31:0];
      end
    end

    if (state == bcp_pkg::ST_OUT && out_free) begin
      m_axis_tdata <= {3'd0, off, r_clamp[13:0], l_clamp[13:0]};
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(mul_start && div_start))
    else $error("both serial units launched together");
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && control_phase) |=> state == bcp_pkg::ST_BAL_P)
    else $error("control tick did not start the balance term");
  assert property (@(posedge clk) disable iff (rst)
    (word_t'(speed_integral) <= bcp_pkg::INTEG_LIMIT)
    && (word_t'(speed_integral) >= -bcp_pkg::INTEG_LIMIT))
    else $error("speed integral beyond its limit");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[13:0]) <= 14'sd6900)
                   && ($signed(m_axis_tdata[13:0]) >= -14'sd6900))
    else $error("left drive beyond saturation");

endmodule

`default_nettype wire

### hdl/bcp_mul.sv
// ----------------------------------------------------------------------------
// bcp_mul: bit-serial shift-add multiplier
// Signed word times unsigned 16-bit operand, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire bcp_pkg::word_t             a,
  input  wire logic [bcp_pkg::MUL_W-1:0]  b,
  output logic                            done,
  output bcp_pkg::word_t                  prod
);

  localparam int CNT_W = $clog2(bcp_pkg::MUL_STEPS + 1);

  bcp_pkg::word_t            ma;
  logic [bcp_pkg::MUL_W-1:0] mb;
  logic [CNT_W-1:0]          cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(bcp_pkg::MUL_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // shift the multiplier out one bit at a time, add the shifted multiplicand
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a;
      mb   <= b;
      prod <= '0;
    end else if (cnt != '0) begin
      if (mb[0]) begin
        prod <= prod + ma;
      end
      ma <= ma <<< 1;
      mb <= mb >> 1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> !done);
  assert property (@(posedge clk) disable iff (rst) done |-> cnt == '0);
  assert property (@(posedge clk) disable iff (rst) (cnt == CNT_W'(1)) |=> done);

endmodule

`default_nettype wire

### hdl/bcp_div.sv
// ----------------------------------------------------------------------------
// bcp_div: bit-serial restoring divider
// Signed dividend over positive divisor, quotient truncated toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire bcp_pkg::word_t             num,
  input  wire logic [bcp_pkg::DEN_W-1:0]  den,
  output logic                            done,
  output bcp_pkg::word_t                  quot
);

  localparam int N     = bcp_pkg::DIV_STEPS;
  localparam int DW    = bcp_pkg::DEN_W;
  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     mag;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             fits;
  bcp_pkg::word_t   abs_num;

  assign abs_num = num[63] ? -num : num;
  assign trial   = {rem, mag[N-1]};
  assign fits    = trial >= {1'b0, dsr};
  assign quot    = neg ? -bcp_pkg::word_t'({{(64-N){1'b0}}, mag})
                       : bcp_pkg::word_t'({{(64-N){1'b0}}, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(N);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      mag <= abs_num[N-1:0];
      rem <= '0;
      dsr <= den;
      neg <= num[63];
    end else if (cnt != '0) begin
      rem <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      mag <= {mag[N-2:0], fits};
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> cnt == '0);
  assert property (@(posedge clk) disable iff (rst) (cnt != '0) |-> rem < dsr);
  assert property (@(posedge clk) disable iff (rst) (cnt == CNT_W'(1)) |=> done);

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-wheel balance controller
// Drives sensor ticks and gain writes over the stream and register channels,
// compares each wheel drive request, bench-predicted or tabled, field by field,
// with random gaps on both sides and several gain settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0]         div;
    logic               stop, right, left, back, fwd;
    logic [11:0]        batt;
    logic signed [15:0] rc, lc, yaw, rate, tilt;
  } tick_t;

  typedef struct packed {
    logic signed [13:0] l, r;
    logic               off;
  } drive_t;

  typedef struct {
    tick_t tick;
    bit    typed;
    drive_t want;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_valid = 0;
  logic [111:0] s_data = '0;
  logic         s_ready;
  logic         m_valid;
  logic         m_ready = 0;
  logic [31:0]  m_data;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  bcp_pkg::reg_index_t cfg_index = bcp_pkg::REG_TILT_KP;
  logic [15:0]  cfg_data = '0;

  balance_robot_cascaded_pid uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor copy of registers and loop state
  longint kp_bal, kd_bal, kp_spd, ki_spd, kp_str, kd_str, level, move_spd;
  bit          ctl_phase;
  int unsigned vsum, vcnt, vavg;
  longint      filt_q16, integ_q16;

  drive_t drive_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     calm_rx = 0;
  int     rx_hold = 0;
  row_t   dir_tab[$];

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void apply_reg(bcp_pkg::reg_index_t idx, logic [15:0] v);
    case (idx)
      bcp_pkg::REG_TILT_KP:    kp_bal = longint'(v);
      bcp_pkg::REG_TILT_KD:    kd_bal = longint'(v);
      bcp_pkg::REG_SPEED_KP:   kp_spd = longint'(v);
      bcp_pkg::REG_SPEED_KI:   ki_spd = longint'(v);
      bcp_pkg::REG_STEER_KP:   kp_str = longint'(v);
      bcp_pkg::REG_STEER_KD:   kd_str = longint'(v);
      bcp_pkg::REG_LEVEL:      level  = longint'($signed(v[12:0]));
      bcp_pkg::REG_MOVE_SPEED: move_spd = longint'(v[9:0]);
    endcase
  endfunction

  // advance the controller by one tick; returns 1 when a drive request results
  function automatic bit drive_for(tick_t t, output drive_t d);
    longint dv, bal, vel, trn, err, filt, mv, integ, num, sgn, kd, l, r;
    bit off;
    ctl_phase ^= 1'b1;
    if (ctl_phase) begin
      vsum = (vsum + t.batt) & 32'h7FFFF;
      vcnt = (vcnt + 1) & 32'h7F;
      if (vcnt == bcp_pkg::AVERAGE_SAMPLES) begin
        vavg = (vsum / bcp_pkg::AVERAGE_SAMPLES) & 32'hFFF;
        vsum = 0;
        vcnt = 0;
      end
      return 0;
    end
    dv = (t.div == 0) ? 1 : longint'(t.div);
    bal = (kp_bal * (longint'(t.tilt) - level) + kd_bal * longint'(t.rate) * 100) / 10000;
    err = -(longint'(t.lc) + longint'(t.rc));
    filt = floor_div(filt_q16 * 56361 + err * 9175 * 65536 + 32768, 65536);
    filt = clampv(filt, -64'sd2147483648, 64'sd2147483647);
    filt_q16 = filt;
    if (t.fwd) mv = (move_spd * 65536) / dv;
    else if (t.back) mv = -((move_spd * 65536) / dv);
    else mv = 0;
    integ = clampv(integ_q16 + filt + mv, -64'sd655360000, 64'sd655360000);
    num = -(filt * kp_spd + integ * ki_spd);
    vel = num / 6553600;
    off = t.tilt < -4000 || t.tilt > 4000 || t.stop || vavg < 1110;
    integ_q16 = off ? 0 : integ;
    sgn = t.left ? -1 : (t.right ? 1 : 0);
    kd = (t.fwd || t.back) ? kd_str : 0;
    num = sgn * 54 * kp_str + longint'(t.yaw) * kd * dv;
    trn = num / (100 * dv);
    l = clampv(bal + vel + trn, -6900, 6900);
    r = clampv(bal + vel - trn, -6900, 6900);
    d.l = l[13:0];
    d.r = r[13:0];
    d.off = off;
    return 1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic tick_t make_tick(bit full);
    tick_t t;
    t = '0;
    if (full) begin
      t.tilt = 16'($urandom_range(0, 36000) - 18000);
      t.rate = 16'($urandom);
      t.yaw  = 16'($urandom);
      t.lc   = 16'($urandom);
      t.rc   = 16'($urandom);
      t.batt = 12'($urandom);
      {t.fwd, t.back, t.left, t.right, t.stop} = 5'($urandom);
      t.div  = 8'($urandom);
    end else begin
      t.tilt = 16'($urandom_range(0, 9000) - 4500);
      t.rate = 16'($urandom_range(0, 6000) - 3000);
      t.yaw  = 16'($urandom_range(0, 6000) - 3000);
      t.lc   = 16'($urandom_range(0, 400) - 200);
      t.rc   = 16'($urandom_range(0, 400) - 200);
      t.batt = 12'($urandom_range(1050, 4095));
      t.fwd  = ($urandom_range(0, 3) == 0);
      t.back = ($urandom_range(0, 3) == 0);
      t.left = ($urandom_range(0, 3) == 0);
      t.right = ($urandom_range(0, 3) == 0);
      t.stop = ($urandom_range(0, 39) == 0);
      t.div  = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return t;
  endfunction

  task automatic send_tick(tick_t t, bit typed, drive_t want);
    int g;
    drive_t d;
    g = gap_len();
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {7'd0, t};
    do @(posedge clk); while (!s_ready);
    if (drive_for(t, d)) drive_q.push_back(typed ? want : d);
  endtask

  // hold the sender until every drive request is back, then let the block settle
  task automatic drain();
    s_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(bcp_pkg::reg_index_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(int kind);
    logic [15:0] v [8];
    case (kind)
      0: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'h0FFF, 16'h03FF};
      1: v = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hF000, 16'h0};
      2: v = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      default: v = '{16'($urandom_range(500, 6000)), 16'($urandom_range(0, 200)),
               16'($urandom_range(0, 30000)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 4000)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(0, 1023))};
    endcase
    for (int i = 0; i < 8; i++) write_reg(bcp_pkg::reg_index_t'(i), v[i]);
  endtask

  function automatic tick_t row(int tilt, int rate, int yaw, int lc, int rc, int batt,
                                logic [4:0] cmd, int dv);
    tick_t t;
    t.tilt = 16'(tilt); t.rate = 16'(rate); t.yaw = 16'(yaw);
    t.lc = 16'(lc); t.rc = 16'(rc);
    t.batt = 12'(batt); {t.fwd, t.back, t.left, t.right, t.stop} = cmd; t.div = 8'(dv);
    return t;
  endfunction

  // receiver: check each accepted request against the oldest expectation
  always @(posedge clk) begin
    drive_t got, want;
    if (!rst) begin
      if (m_valid && m_ready) begin
        got = {m_data[13:0], m_data[27:14], m_data[28]};
        if (drive_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected drive request %h", m_data);
        end else begin
          want = drive_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("drive mismatch: want l=%0d r=%0d off=%0b got l=%0d r=%0d off=%0b",
                       want.l, want.r, want.off, got.l, got.r, got.off);
          end
        end
      end
      if (calm_rx || rx_hold == 0) begin
        m_ready <= 1'b1;
        if (!calm_rx) rx_hold = -gap_len();
      end else m_ready <= 1'b0;
      if (rx_hold < 0) rx_hold = -rx_hold;
      else if (rx_hold > 0) rx_hold--;
    end
  end

  // watchdog: cycles with no accepted request of any kind
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    drive_t zero_off;
    zero_off = '{l: 14'sd0, r: 14'sd0, off: 1'b1};
    kp_bal = 0; kd_bal = 0; kp_spd = 0; ki_spd = 0; kp_str = 0; kd_str = 0;
    level = 0; move_spd = 35;
    ctl_phase = 0; vsum = 0; vcnt = 0; vavg = 0; filt_q16 = 0; integ_q16 = 0;
    // extremes, every command, zero divisor, tilt limits and stop
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(18000, 32767, 32767, 32767, 32767, 0, 5'b10000, 0), 1, zero_off});
    dir_tab.push_back('{row(-18000, -32768, -32768, -32768, -32768, 4095, 5'b00000, 255),
                        1, zero_off});
    dir_tab.push_back('{row(4000, 100, -500, 10, 12, 2048, 5'b01000, 1), 1, zero_off});
    dir_tab.push_back('{row(4001, 0, 0, 0, 0, 1109, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(-4001, -100, 500, -7, 3, 1111, 5'b00100, 7), 1, zero_off});
    dir_tab.push_back('{row(-4000, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(10, 20, 30, 40, 50, 1, 5'b00010, 255), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 1000, 0, 0, 0, 5'b11000, 3), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(0, 0, -1000, 0, 0, 0, 5'b10110, 0), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(200, 0, 0, 0, 0, 0, 5'b00001, 2), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(-1, -1, -1, -1, -1, 0, 5'b01100, 128), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 4095, 5'b00000, 1), 1, zero_off});
    dir_tab.push_back('{row(0, 0, 0, 0, 0, 0, 5'b11111, 255), 1, zero_off});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // same rows under full-scale gains, checked against the predictor
    set_gains(0);
    foreach (dir_tab[i]) send_tick(dir_tab[i].tick, 0, dir_tab[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_gains(ph == 0 ? 3 : (ph == 1 ? 0 : (ph == 2 ? 1 : (ph == 3 ? 2 : 3))));
      calm_rx = (ph == 4);
      for (int n = 0; n < 320; n++) begin
        if (ph == 2 && n == 160) drain();
        send_tick(make_tick($urandom_range(0, 99) < 15), 0, zero_off);
      end
      drain();
    end
    calm_rx = 0;

    if (errors == 0 && drive_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/bcp_pkg.sv
hdl/bcp_mul.sv
hdl/bcp_div.sv
hdl/balance_robot_cascaded_pid.sv
bench/tb_top.sv
